// ===== hw/rtl/pbb_pkg.sv =====
`timescale 1ns / 1ps

package pbb_pkg;

    localparam int CFG_ADDR_W = 1;
    localparam int ORDER_W    = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_ERASURE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ORDER   = 1'd1;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd10;

endpackage

// ===== hw/rtl/pbb_cell.sv =====
`timescale 1ns / 1ps

module pbb_cell #(
    parameter int FRAC_BITS = 16,
    parameter int IDX_W     = 10,
    parameter int ORD_W     = 4,
    parameter int POS       = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 valid_in,
    input  logic [FRAC_BITS:0]   z_in,
    input  logic [IDX_W-1:0]     idx_in,
    input  logic [ORD_W-1:0]     order,
    output logic                 valid_out,
    output logic [FRAC_BITS:0]   z_out,
    output logic [IDX_W-1:0]     idx_out
);

    localparam int ZW = FRAC_BITS + 1;
    localparam logic [ZW-1:0]    ONE     = ZW'(1) << FRAC_BITS;
    localparam logic [ORD_W-1:0] POS_ORD = ORD_W'(POS);

    logic                   valid_reg;
    logic [ZW-1:0]          z_reg;
    logic [ZW-1:0]          z_next;
    logic [IDX_W-1:0]       idx_reg;
    logic [2*FRAC_BITS-1:0] prod;
    logic [FRAC_BITS-1:0]   sq;
    logic [ZW:0]            merged;
    logic                   active;

    assign active = order > POS_ORD;
    assign prod   = z_in[FRAC_BITS-1:0] * z_in[FRAC_BITS-1:0];
    assign sq     = prod[2*FRAC_BITS-1:FRAC_BITS];
    assign merged = {z_in, 1'b0} - {2'b00, sq};

    always_comb begin
        if (!active || z_in[FRAC_BITS]) begin
            z_next = z_in;
        end else if (idx_in[POS]) begin
            z_next = {1'b0, sq};
        end else if (merged > {1'b0, ONE}) begin
            z_next = ONE;
        end else begin
            z_next = merged[ZW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z_reg   <= z_next;
            idx_reg <= idx_in;
        end
    end

    assign valid_out = valid_reg;
    assign z_out     = z_reg;
    assign idx_out   = idx_reg;

endmodule

// ===== hw/rtl/polar_bec_bhattacharyya.sv =====
`timescale 1ns / 1ps
// every request passes through all MAX_ORDER map cells to m_tvalid, whatever the code_order
// throughput: one request per cycle when not stalled; MAX_ORDER map cells, one multiply each
// the whole row stalls together while a result waits on m_tready
// reset (aresetn low, synchronous) empties the row, erasure_prob = one half, code_order = 10

module polar_bec_bhattacharyya #(
    parameter int MAX_ORDER = 10,
    parameter int FRAC_BITS = 16
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // channel_index
    input  logic [((MAX_ORDER+7)/8)*8-1:0]             s_tdata,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // bhattacharyya, capacity
    output logic [((2*(FRAC_BITS+1)+7)/8)*8-1:0]       m_tdata,
    input  logic                                       cfg_we,
    input  logic [pbb_pkg::CFG_ADDR_W-1:0]             cfg_addr,
    input  logic [FRAC_BITS:0]                         cfg_wdata
);

    localparam int ZW    = FRAC_BITS + 1;
    localparam int MW    = ((2 * ZW + 7) / 8) * 8;
    localparam int ORD_W = (pbb_pkg::ORDER_W > $clog2(MAX_ORDER + 1))
                           ? pbb_pkg::ORDER_W : $clog2(MAX_ORDER + 1);
    localparam logic [ZW-1:0]    ONE     = ZW'(1) << FRAC_BITS;
    localparam logic [ORD_W-1:0] MAX_ORD = ORD_W'(MAX_ORDER);

    logic [ZW-1:0]                      erasure_reg;
    logic [pbb_pkg::ORDER_W-1:0]        order_reg;
    logic [ORD_W-1:0]                   order_wide;
    logic [ORD_W-1:0]                   order_eff;
    logic [ZW-1:0]                      z_start;
    logic                               en;

    logic [MAX_ORDER:0]                 valid_chain;
    logic [MAX_ORDER:0][ZW-1:0]         z_chain;
    logic [MAX_ORDER:0][MAX_ORDER-1:0]  idx_chain;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            erasure_reg <= ONE >> 1;
            order_reg   <= pbb_pkg::ORDER_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                pbb_pkg::REG_ERASURE: erasure_reg <= cfg_wdata;
                pbb_pkg::REG_ORDER:   order_reg   <= cfg_wdata[pbb_pkg::ORDER_W-1:0];
                default: ;
            endcase
        end
    end

    assign order_wide = ORD_W'(order_reg);
    assign order_eff  = (order_wide > MAX_ORD) ? MAX_ORD : order_wide;
    assign z_start    = (erasure_reg > ONE) ? ONE : erasure_reg;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign valid_chain[0] = s_tvalid;
    assign z_chain[0]     = z_start;
    assign idx_chain[0]   = s_tdata[MAX_ORDER-1:0];

    for (genvar i = 0; i < MAX_ORDER; i++) begin : g_cell
        pbb_cell #(
            .FRAC_BITS (FRAC_BITS),
            .IDX_W     (MAX_ORDER),
            .ORD_W     (ORD_W),
            .POS       (MAX_ORDER - 1 - i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (valid_chain[i]),
            .z_in      (z_chain[i]),
            .idx_in    (idx_chain[i]),
            .order     (order_eff),
            .valid_out (valid_chain[i+1]),
            .z_out     (z_chain[i+1]),
            .idx_out   (idx_chain[i+1])
        );
    end

    assign m_tvalid = valid_chain[MAX_ORDER];
    assign m_tdata  = MW'({ONE - z_chain[MAX_ORDER], z_chain[MAX_ORDER]});

endmodule

// ===== hw/rtl/pbb_checker.sv =====
`timescale 1ns / 1ps

module pbb_checker #(
    parameter int MAX_ORDER = 10,
    parameter int FRAC_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tready,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [((2*(FRAC_BITS+1)+7)/8)*8-1:0] m_tdata
);

    localparam int ZW = FRAC_BITS + 1;
    localparam logic [ZW:0] ONE = (ZW+1)'(1) << FRAC_BITS;

    logic [ZW-1:0] bhat;
    logic [ZW-1:0] cap;

    assign bhat = m_tdata[ZW-1:0];
    assign cap  = m_tdata[2*ZW-1:ZW];

    a_sum_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, bhat} + {1'b0, cap} == ONE))
        else $error("bhattacharyya and capacity do not sum to one");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, bhat} <= ONE))
        else $error("bhattacharyya above one");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked while output empty");

    a_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind polar_bec_bhattacharyya pbb_checker #(
    .MAX_ORDER (MAX_ORDER),
    .FRAC_BITS (FRAC_BITS)
) u_pbb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
